[sv/wfd_pkg.sv]
// Shared constants, codes and types for the WebSocket frame deframer.
package wfd_pkg;

	localparam int LENGTH_BITS = 64;

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	localparam logic [1:0] KIND_TEXT       = 2'd0;
	localparam logic [1:0] KIND_CLOSE      = 2'd1;
	localparam logic [1:0] KIND_OTHER      = 2'd2;
	localparam logic [1:0] KIND_EMPTY_TEXT = 2'd3;

	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef logic [LENGTH_BITS-1:0] len_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       last;
	} res_t;

endpackage

[sv/wfd_in_stage.sv]
// Input register stage holding one received byte for the parser.
module wfd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte[7:0]
	input  logic       take,
	output logic       in_valid,
	output logic [7:0] in_byte
);
	import wfd_pkg::*;

	logic       valid_q;
	logic [7:0] byte_s1;

	assign s_tready = !valid_q || take;
	assign in_valid = valid_q;
	assign in_byte  = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

[sv/wfd_parser.sv]
// Frame parsing state and per-byte next-state and result logic.
module wfd_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [7:0]   in_byte,
	input  logic         out_free,
	output logic         take,
	output logic         res_valid,
	output wfd_pkg::res_t res
);
	import wfd_pkg::*;

	logic [2:0]  phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_en_q, mask_en_d;
	logic [3:0]  bytes_left_q, bytes_left_d;
	len_t        remaining_q, remaining_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  mask_idx_q, mask_idx_d;

	logic        hdr_done;
	logic        after_len;
	logic [3:0]  left_dec;
	logic [7:0]  key_byte;
	logic [1:0]  end_kind;
	len_t        rem_dec;

	assign left_dec = bytes_left_q - 4'd1;
	assign rem_dec  = remaining_q - len_t'(1);

	always_comb begin
		unique case (mask_idx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		if (opcode_d == OP_CLOSE) begin
			end_kind = KIND_CLOSE;
		end else if (opcode_d == OP_TEXT) begin
			end_kind = KIND_EMPTY_TEXT;
		end else begin
			end_kind = KIND_OTHER;
		end
	end

	always_comb begin
		phase_d      = phase_q;
		opcode_d     = opcode_q;
		mask_en_d    = mask_en_q;
		bytes_left_d = bytes_left_q;
		remaining_d  = remaining_q;
		key_d        = key_q;
		mask_idx_d   = mask_idx_q;
		after_len    = 1'b0;
		hdr_done     = 1'b0;
		res_valid    = 1'b0;
		res          = '0;

		unique case (phase_q)
			PH_HDR1: begin
				mask_en_d = in_byte[7];
				if (in_byte[6:0] == LEN_CODE_16) begin
					remaining_d  = '0;
					bytes_left_d = EXT16_BYTES;
					phase_d      = PH_EXTLEN;
				end else if (in_byte[6:0] == LEN_CODE_64) begin
					remaining_d  = '0;
					bytes_left_d = EXT64_BYTES;
					phase_d      = PH_EXTLEN;
				end else begin
					remaining_d = len_t'(in_byte[6:0]);
					after_len   = 1'b1;
				end
			end
			PH_EXTLEN: begin
				if (remaining_q[LENGTH_BITS-1 -: 8] != 8'd0) begin
					remaining_d = '1;
				end else begin
					remaining_d = {remaining_q[LENGTH_BITS-9:0], in_byte};
				end
				bytes_left_d = left_dec;
				after_len    = (left_dec == 4'd0);
			end
			PH_MASK: begin
				key_d        = {key_q[23:0], in_byte};
				bytes_left_d = left_dec;
				hdr_done     = (left_dec == 4'd0);
			end
			PH_PAYLOAD: begin
				mask_idx_d  = mask_idx_q + 2'd1;
				remaining_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_HDR0;
				end
				if (opcode_q == OP_TEXT) begin
					res_valid     = 1'b1;
					res.kind      = KIND_TEXT;
					res.data_byte = in_byte ^ key_byte;
					res.last      = (rem_dec == '0);
				end else if (rem_dec == '0) begin
					res_valid = 1'b1;
					res.kind  = (opcode_q == OP_CLOSE) ? KIND_CLOSE : KIND_OTHER;
					res.last  = 1'b1;
				end
			end
			default: begin
				opcode_d = in_byte[3:0];
				phase_d  = PH_HDR1;
			end
		endcase

		if (after_len) begin
			key_d = '0;
			if (mask_en_d) begin
				phase_d      = PH_MASK;
				bytes_left_d = KEY_BYTES;
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			mask_idx_d = 2'd0;
			if (remaining_d != '0) begin
				phase_d = PH_PAYLOAD;
			end else begin
				phase_d   = PH_HDR0;
				res_valid = 1'b1;
				res.kind  = end_kind;
				res.last  = 1'b1;
			end
		end
	end

	assign take = in_valid && (!res_valid || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR0;
			opcode_q     <= '0;
			mask_en_q    <= 1'b0;
			bytes_left_q <= '0;
			remaining_q  <= '0;
			key_q        <= '0;
			mask_idx_q   <= '0;
		end else if (take) begin
			phase_q      <= phase_d;
			opcode_q     <= opcode_d;
			mask_en_q    <= mask_en_d;
			bytes_left_q <= bytes_left_d;
			remaining_q  <= remaining_d;
			key_q        <= key_d;
			mask_idx_q   <= mask_idx_d;
		end
	end

endmodule

[sv/wfd_out_stage.sv]
// Result register driving the output stream.
module wfd_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wfd_pkg::res_t res,
	output logic          out_free,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,   // data_byte[7:0]
	output logic [1:0]    m_tuser,   // kind[1:0]
	output logic          m_tlast
);
	import wfd_pkg::*;

	logic valid_q;
	res_t res_s2;

	assign out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = res_s2.data_byte;
	assign m_tuser  = res_s2.kind;
	assign m_tlast  = res_s2.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_s2 <= res;
		end
	end

endmodule

[sv/websocket_frame_deframer_unit.sv]
// Top level of the WebSocket frame deframer: input stage, parser, result stage.
//
//  Channel  Direction  Beat content
//  s_*      in         tdata = received byte
//  m_*      out        tdata = unmasked payload byte, tuser = kind, tlast = frame end
//
// Every byte is held in the input register; a byte that gives a result moves on to the result register,
// which offers it on m_*; one byte per cycle unless a result waits on a stalled output.
// The parse state advances once per byte as it leaves the input register.
// Reset returns the parser to the first header byte of a frame.
// A stalled output holds its beat; bytes that give no result still move on.
module websocket_frame_deframer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte[7:0]
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // data_byte[7:0]
	output logic [1:0] m_tuser,   // kind[1:0]
	output logic       m_tlast
);
	import wfd_pkg::*;

	logic       take;
	logic       in_valid;
	logic [7:0] in_byte;
	logic       out_free;
	logic       res_valid;
	res_t       res;

	wfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (take),
		.in_valid (in_valid),
		.in_byte  (in_byte)
	);

	wfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_byte   (in_byte),
		.out_free  (out_free),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	wfd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take && res_valid),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[sim/tb_websocket_frame_deframer_unit.sv]
// Self-checking testbench for the WebSocket frame deframer with a built-in frame predictor.
module tb_websocket_frame_deframer_unit;
	import wfd_pkg::*;

	localparam int STREAM_BYTES = 1880;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_FROM = 1500;
	localparam int HOLD_CYCLES = 300;
	localparam int FORM_SHORT = 0;
	localparam int FORM_EXT16 = 1;
	localparam int FORM_EXT64 = 2;
	localparam res_t NO_RESULT = res_t'(0);

	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		res_t       want;
	} rx_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	rx_byte_t rx_stream[$];
	res_t     pending_beats[$];
	int       bytes_taken = 0;
	int       mismatches = 0;
	int       quiet_cycles = 0;
	int       rx_cycle = 0;

	// Parser state kept by the predictor.
	logic [2:0]  ph = PH_HDR0;
	logic [3:0]  op = 4'h0;
	logic        masked = 1'b0;
	logic [3:0]  hdr_left = 4'h0;
	len_t        remaining = '0;
	logic [31:0] key = 32'h0;
	logic [1:0]  key_idx = 2'd0;

	logic got;
	res_t predicted;
	res_t oldest;

	rx_byte_t directed_rows [0:26] = '{
		'{8'h81, 1'b0, NO_RESULT},
		'{8'h00, 1'b1, {KIND_EMPTY_TEXT, 8'h00, 1'b1}},
		'{8'h88, 1'b0, NO_RESULT},
		'{8'h80, 1'b0, NO_RESULT},
		'{8'h12, 1'b0, NO_RESULT},
		'{8'h34, 1'b0, NO_RESULT},
		'{8'h56, 1'b0, NO_RESULT},
		'{8'h78, 1'b1, {KIND_CLOSE, 8'h00, 1'b1}},
		'{8'h0F, 1'b0, NO_RESULT},
		'{8'h01, 1'b0, NO_RESULT},
		'{8'hE7, 1'b1, {KIND_OTHER, 8'h00, 1'b1}},
		'{8'h81, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, NO_RESULT},
		'{8'h02, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, NO_RESULT},
		'{8'hA5, 1'b0, NO_RESULT},
		'{8'h5A, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, NO_RESULT}
	};

	websocket_frame_deframer_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic res_t frame_status();
		if (op == OP_CLOSE)
			return {KIND_CLOSE, 8'h00, 1'b1};
		if (op == OP_TEXT)
			return {KIND_EMPTY_TEXT, 8'h00, 1'b1};
		return {KIND_OTHER, 8'h00, 1'b1};
	endfunction

	task automatic finish_header(output logic has_beat, output res_t beat);
		key_idx = 2'd0;
		has_beat = 1'b0;
		beat = NO_RESULT;
		if (remaining != '0) begin
			ph = PH_PAYLOAD;
		end else begin
			ph = PH_HDR0;
			has_beat = 1'b1;
			beat = frame_status();
		end
	endtask

	task automatic finish_length(output logic has_beat, output res_t beat);
		key = 32'h0;
		has_beat = 1'b0;
		beat = NO_RESULT;
		if (masked) begin
			ph = PH_MASK;
			hdr_left = KEY_BYTES;
		end else begin
			finish_header(has_beat, beat);
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b, output logic has_beat, output res_t beat);
		logic [7:0] plain;
		logic       fin;
		has_beat = 1'b0;
		beat = NO_RESULT;
		case (ph)
			PH_HDR1: begin
				masked = b[7];
				if (b[6:0] == LEN_CODE_16 || b[6:0] == LEN_CODE_64) begin
					remaining = '0;
					hdr_left = (b[6:0] == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
					ph = PH_EXTLEN;
				end else begin
					remaining = len_t'(b[6:0]);
					finish_length(has_beat, beat);
				end
			end
			PH_EXTLEN: begin
				if (remaining[LENGTH_BITS-1 -: 8] != 8'h00)
					remaining = '1;
				else
					remaining = {remaining[LENGTH_BITS-9:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left == 4'd0)
					finish_length(has_beat, beat);
			end
			PH_MASK: begin
				key = {key[23:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left == 4'd0)
					finish_header(has_beat, beat);
			end
			PH_PAYLOAD: begin
				plain = b ^ 8'(key >> (8 * (3 - int'(key_idx))));
				key_idx = key_idx + 2'd1;
				remaining = remaining - len_t'(1);
				fin = (remaining == '0);
				if (fin)
					ph = PH_HDR0;
				if (op == OP_TEXT) begin
					has_beat = 1'b1;
					beat = {KIND_TEXT, plain, fin};
				end else if (fin) begin
					has_beat = 1'b1;
					beat = frame_status();
				end
			end
			default: begin
				op = b[3:0];
				ph = PH_HDR1;
			end
		endcase
	endtask

	function automatic void push_byte(input logic [7:0] b);
		rx_byte_t row;
		row = '{b, 1'b0, NO_RESULT};
		rx_stream.insert(rx_stream.size(), row);
	endfunction

	task automatic add_frame(input logic [3:0] opcode, input logic use_key, input int form,
			input logic [63:0] len, input int body);
		logic [6:0] code;
		code = (form == FORM_SHORT) ? len[6:0] : (form == FORM_EXT16) ? LEN_CODE_16 : LEN_CODE_64;
		push_byte({4'($urandom), opcode});
		push_byte({use_key, code});
		if (form == FORM_EXT16) begin
			push_byte(len[15:8]);
			push_byte(len[7:0]);
		end else if (form == FORM_EXT64) begin
			for (int k = 7; k >= 0; k--)
				push_byte(8'(len >> (8 * k)));
		end
		if (use_key) begin
			for (int k = 0; k < 4; k++)
				push_byte(8'($urandom));
		end
		for (int k = 0; k < body; k++)
			push_byte(8'($urandom));
	endtask

	task automatic build_stream();
		logic [3:0] opcode;
		int pick;
		int len;
		int form;
		foreach (directed_rows[i])
			rx_stream.insert(rx_stream.size(), directed_rows[i]);
		while (rx_stream.size() < STREAM_BYTES) begin
			pick = $urandom_range(0, 99);
			opcode = (pick < 50) ? OP_TEXT : (pick < 65) ? OP_CLOSE : 4'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 60)
				len = $urandom_range(0, 8);
			else if (pick < 85)
				len = $urandom_range(9, 40);
			else if (pick < 95)
				len = $urandom_range(41, 125);
			else
				len = $urandom_range(126, 300);
			pick = $urandom_range(0, 99);
			if (len > 125)
				form = $urandom_range(FORM_EXT16, FORM_EXT64);
			else
				form = (pick < 70) ? FORM_SHORT : (pick < 90) ? FORM_EXT16 : FORM_EXT64;
			add_frame(opcode, 1'($urandom), form, 64'(len), len);
		end
		// A text frame whose 64-bit length has the top bit set never ends; it closes the run.
		add_frame(OP_TEXT, 1'b1, FORM_EXT64, {1'b1, 31'($urandom), 32'($urandom)}, 40);
	endtask

	initial begin
		int idx;
		int burst;
		int gap;
		build_stream();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idx = 0;
		while (idx < rx_stream.size()) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && idx < rx_stream.size()) begin
				s_tvalid <= 1'b1;
				s_tdata <= rx_stream[idx].b;
				@(posedge clk);
				while (!s_tready)
					@(posedge clk);
				idx++;
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				s_tdata <= 8'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
		while (bytes_taken < rx_stream.size() || pending_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_FROM + HOLD_CYCLES) begin
				m_tready <= 1'b0;
			end else begin
				case (rx_cycle[8:7])
					2'd0: m_tready <= 1'b1;
					2'd1: m_tready <= 1'($urandom);
					2'd2: m_tready <= (rx_cycle[1:0] != 2'd0);
					default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				deframe_byte(s_tdata, got, predicted);
				if (rx_stream[bytes_taken].typed)
					pending_beats.insert(pending_beats.size(), rx_stream[bytes_taken].want);
				else if (got)
					pending_beats.insert(pending_beats.size(), predicted);
				bytes_taken++;
			end
			if (m_tvalid && m_tready) begin
				if (pending_beats.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected beat: kind %0d data %02h last %0d",
							m_tuser, m_tdata, m_tlast);
					mismatches++;
				end else begin
					oldest = pending_beats.pop_front();
					if (m_tuser !== oldest.kind || m_tdata !== oldest.data_byte
							|| m_tlast !== oldest.last) begin
						if (mismatches < 10)
							$display("beat mismatch: expected kind %0d data %02h last %0d, got kind %0d data %02h last %0d",
								oldest.kind, oldest.data_byte, oldest.last,
								m_tuser, m_tdata, m_tlast);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

[websocket_frame_deframer_unit.f]
sv/wfd_pkg.sv
sv/wfd_in_stage.sv
sv/wfd_parser.sv
sv/wfd_out_stage.sv
sv/websocket_frame_deframer_unit.sv
sim/tb_websocket_frame_deframer_unit.sv
